// ===== hdl/sdq_pkg.sv =====
// sdq_pkg: shared types and constants for the searchable deque.
// Used by sdq_ctrl, sdq_datapath and the searchable_deque top level.
package sdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_FIND       = 3'd4;
  localparam logic [FUNC_W-1:0] OP_REMOVE     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming beat
    logic exec;  // carry out the captured operation, load the result register
  } ctl_t;

endpackage

// ===== hdl/searchable_deque.sv =====
// searchable_deque: bounded double-ended queue of keys with find and remove.
// After a beat is accepted, it is carried out in the S_EXEC state, and out_valid
// then rises as the controller enters S_DONE. No new beat is taken while one is
// carried out or its result waits; the next beat is taken in the cycle the waiting result is taken.
// Reset (synchronous, rst_n low) empties the queue; cell contents are not cleared.
// Depends on sdq_pkg, sdq_ctrl and sdq_datapath.
module searchable_deque #(
  parameter int DEPTH = sdq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sdq_pkg::FUNC_W-1:0]     in_func,
  input  logic [sdq_pkg::KEY_W-1:0]      in_key_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sdq_pkg::KEY_W-1:0]      out_result_value,
  output logic                           out_found,
  output logic [sdq_pkg::STAT_W-1:0]     out_status,
  output logic [sdq_pkg::CNT_OUT_W-1:0]  out_entry_count
);

  sdq_pkg::ctl_t ctl;

  sdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  sdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_func          (in_func),
    .in_key_value     (in_key_value),
    .out_result_value (out_result_value),
    .out_found        (out_found),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

`ifndef SYNTHESIS
  // accepted beat is being worked on next cycle, so no result is shown then
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in the cycle after a beat was taken");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == sdq_pkg::ST_OK)
    else $error("found flag with non-ok status");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sdq_pkg::ST_EMPTY |-> out_entry_count == '0)
    else $error("empty status with entries held");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sdq_pkg::ST_OK |-> out_result_value == '0 && !out_found)
    else $error("value or found flag on a failed operation");
`endif

endmodule

// ===== hdl/sdq_ctrl.sv =====
// sdq_ctrl: handshake controller for the searchable deque.
// Depends on sdq_pkg for the command struct.
module sdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sdq_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  // a new beat may enter in the cycle the waiting result leaves
  assign in_ready  = (state_r == S_IDLE) || (state_r == S_DONE && out_ready);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign ctl.load  = take;
  assign ctl.exec  = (state_r == S_EXEC);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_DONE;
        out_valid_nxt = 1'b1;
      end
      S_DONE: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = take ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/sdq_datapath.sv =====
// sdq_datapath: row of key cells with parallel compare and one-step shifts,
// plus the occupancy count and the result register. Depends on sdq_pkg.
module sdq_datapath #(
  parameter int DEPTH = sdq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sdq_pkg::ctl_t                  ctl,
  input  logic [sdq_pkg::FUNC_W-1:0]     in_func,
  input  logic [sdq_pkg::KEY_W-1:0]      in_key_value,
  output logic [sdq_pkg::KEY_W-1:0]      out_result_value,
  output logic                           out_found,
  output logic [sdq_pkg::STAT_W-1:0]     out_status,
  output logic [sdq_pkg::CNT_OUT_W-1:0]  out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = sdq_pkg::KEY_W;
  localparam int OW = sdq_pkg::CNT_OUT_W;

  logic [sdq_pkg::FUNC_W-1:0] op_r;
  logic [KW-1:0]              key_r;
  logic [KW-1:0]              ent_r [DEPTH];
  logic [CW-1:0]              cnt_r, cnt_nxt;

  logic [KW-1:0]              res_val_r, res_val_nxt;
  logic                       res_fnd_r, res_fnd_nxt;
  logic [sdq_pkg::STAT_W-1:0] res_st_r, res_st_nxt;
  logic [OW-1:0]              res_cnt_r;
  logic [CW+OW-1:0]           cnt_ext;

  logic [DEPTH-1:0] vld, match, first, ge, last, nb;
  logic [DEPTH-1:0] up_en, dn_en, key_en;
  logic [KW-1:0]    tail_val;
  logic             full, empty, hit;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  // per-cell occupancy and key compare
  for (genvar g = 0; g < DEPTH; g++) begin : g_cmp
    assign vld[g]   = (cnt_r > CW'(g));
    assign match[g] = vld[g] && (ent_r[g] == key_r);
  end

  assign hit   = |match;
  assign first = match & (~match + 1'b1);     // lowest matching cell
  assign ge    = ~(first - 1'b1);             // that cell and all behind it
  assign last  = vld & ~(vld >> 1);           // back entry
  assign nb    = ~vld & {vld[DEPTH-2:0], 1'b1}; // first free cell

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | (ent_r[i] & {KW{last[i]}});
    end
  end

  always_comb begin
    up_en       = '0;
    dn_en       = '0;
    key_en      = '0;
    cnt_nxt     = cnt_r;
    res_val_nxt = '0;
    res_fnd_nxt = 1'b0;
    res_st_nxt  = sdq_pkg::ST_OK;
    case (op_r)
      sdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res_st_nxt = sdq_pkg::ST_FULL;
        end else begin
          up_en   = '1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      sdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          res_st_nxt = sdq_pkg::ST_FULL;
        end else begin
          key_en  = nb;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      sdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          res_st_nxt = sdq_pkg::ST_EMPTY;
        end else begin
          res_val_nxt = ent_r[0];
          dn_en       = '1;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      sdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          res_st_nxt = sdq_pkg::ST_EMPTY;
        end else begin
          res_val_nxt = tail_val;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      sdq_pkg::OP_FIND: begin
        res_fnd_nxt = hit;
        res_val_nxt = hit ? key_r : '0;
      end
      sdq_pkg::OP_REMOVE: begin
        res_fnd_nxt = hit;
        res_val_nxt = hit ? key_r : '0;
        if (hit) begin
          dn_en   = ge;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // cells: shift toward the back, shift toward the front, or load the key
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KW-1:0] up_src, dn_src;
    if (g == 0) begin : g_head
      assign up_src = key_r;
    end else begin : g_body
      assign up_src = ent_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign dn_src = ent_r[g];
    end else begin : g_rest
      assign dn_src = ent_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.exec) begin
        if (up_en[g]) begin
          ent_r[g] <= up_src;
        end else if (dn_en[g]) begin
          ent_r[g] <= dn_src;
        end else if (key_en[g]) begin
          ent_r[g] <= key_r;
        end
      end
    end
  end

  assign cnt_ext = {{OW{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= in_func;
      key_r <= in_key_value;
    end
    if (ctl.exec) begin
      res_val_r <= res_val_nxt;
      res_fnd_r <= res_fnd_nxt;
      res_st_r  <= res_st_nxt;
      res_cnt_r <= cnt_ext[OW-1:0];
    end
  end

  assign out_result_value = res_val_r;
  assign out_found        = res_fnd_r;
  assign out_status       = res_st_r;
  assign out_entry_count  = res_cnt_r;

endmodule

// ===== test/tb_searchable_deque.sv =====
// tb_searchable_deque: self-checking testbench for the searchable deque.
// Needs sdq_pkg and the searchable_deque RTL. Predicts each result in step with
// accepted input beats and checks them in order against the block's outputs.
`timescale 1ns / 100ps

module tb_searchable_deque;

  localparam int FUNC_W      = sdq_pkg::FUNC_W;
  localparam int KEY_W       = sdq_pkg::KEY_W;
  localparam int STAT_W      = sdq_pkg::STAT_W;
  localparam int CNT_OUT_W   = sdq_pkg::CNT_OUT_W;
  localparam int QDEPTH      = sdq_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 120;

  // codes the block must treat as no-ops
  localparam logic [FUNC_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  key;
    bit                drain;  // not a beat: wait until every result is back
  } deque_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]     value;
    logic                 found;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count;
  } deque_res_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [KEY_W-1:0] in_key_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0] out_result_value;
  logic out_found;
  logic [STAT_W-1:0] out_status;
  logic [CNT_OUT_W-1:0] out_entry_count;

  deque_req_t pending_ops[$];
  deque_res_t expected_results[$];

  // shadow copy of the deque contents, entry 0 is the front
  logic [KEY_W-1:0] shadow_entries[QDEPTH];
  int shadow_len = 0;

  bit in_taken = 1'b0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int cycles = 0;
  int burst_left = 8;
  int gap_left = 0;
  int hold_left = 0;
  int next_hold_at = 300;
  logic [7:0] ready_pat = 8'hff;
  int rx_phase = 0;

  searchable_deque #(.DEPTH(QDEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_key_value(in_key_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_value(out_result_value),
    .out_found(out_found),
    .out_status(out_status),
    .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one operation to the shadow deque and returns the result it gives.
  function automatic deque_res_t predict_deque_op(input logic [FUNC_W-1:0] op,
                                                  input logic [KEY_W-1:0] key);
    deque_res_t r;
    int pos;
    r = '0;
    pos = -1;
    case (op)
      sdq_pkg::OP_PUSH_FRONT: begin
        if (shadow_len >= QDEPTH) begin
          r.status = sdq_pkg::ST_FULL;
        end else begin
          for (int i = shadow_len; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = key;
          shadow_len++;
        end
      end
      sdq_pkg::OP_PUSH_BACK: begin
        if (shadow_len >= QDEPTH) begin
          r.status = sdq_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_len] = key;
          shadow_len++;
        end
      end
      sdq_pkg::OP_POP_FRONT, sdq_pkg::OP_POP_BACK: begin
        if (shadow_len == 0) begin
          r.status = sdq_pkg::ST_EMPTY;
        end else begin
          pos = (op == sdq_pkg::OP_POP_FRONT) ? 0 : shadow_len - 1;
          r.value = shadow_entries[pos];
        end
      end
      sdq_pkg::OP_FIND, sdq_pkg::OP_REMOVE: begin
        for (int i = shadow_len - 1; i >= 0; i--)
          if (shadow_entries[i] == key) pos = i;
        if (pos >= 0) begin
          r.value = shadow_entries[pos];
          r.found = 1'b1;
        end
        if (op == sdq_pkg::OP_FIND) pos = -1;
      end
      default: ;
    endcase
    // close the gap left by a pop or a matched remove
    if (pos >= 0) begin
      for (int i = pos; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
      shadow_len--;
    end
    r.count = CNT_OUT_W'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    n_errors++;
    $display("mismatch in %s of result %0d: got %h, expected %h",
             field, n_results, got, want);
  endtask

  task automatic add_op(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key);
    pending_ops.push_back('{op: op, key: key, drain: 1'b0});
  endtask

  task automatic add_drain();
    pending_ops.push_back('{op: sdq_pkg::OP_FIND, key: '0, drain: 1'b1});
  endtask

  function automatic logic [FUNC_W-1:0] pick_op(input int mode);
    int r;
    int push_lim;
    int pop_lim;
    r = $urandom_range(0, 99);
    push_lim = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 20 : 35;
    pop_lim  = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 75 : 65;
    if (r < push_lim) return r[0] ? sdq_pkg::OP_PUSH_BACK : sdq_pkg::OP_PUSH_FRONT;
    if (r < pop_lim) return r[0] ? sdq_pkg::OP_POP_BACK : sdq_pkg::OP_POP_FRONT;
    if (r < 83) return sdq_pkg::OP_FIND;
    if (r < 98) return sdq_pkg::OP_REMOVE;
    return r[0] ? OP_UNUSED_7 : OP_UNUSED_6;
  endfunction

  // monitor: predicts on accepted input beats, checks accepted result beats
  always @(posedge clk) begin
    deque_res_t want;
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("presence", out_result_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_result_value !== want.value)
            report_mismatch("result_value", out_result_value, want.value);
          if (out_found !== want.found)
            report_mismatch("found", KEY_W'(out_found), KEY_W'(want.found));
          if (out_status !== want.status)
            report_mismatch("status", KEY_W'(out_status), KEY_W'(want.status));
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", KEY_W'(out_entry_count), KEY_W'(want.count));
        end
        n_results++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_deque_op(in_func, in_key_value));
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // driver: bursts of beats with random gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_ops[0].drain) begin
        in_valid <= 1'b0;
        if (expected_results.size() == 0) void'(pending_ops.pop_front());
      end else begin
        in_func <= pending_ops[0].op;
        in_key_value <= pending_ops[0].key;
        in_valid <= 1'b1;
        void'(pending_ops.pop_front());
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern from ready_pat, reloaded at random as rx_phase runs on, plus occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (n_accepted >= next_hold_at) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      next_hold_at <= next_hold_at + 700;
    end else begin
      out_ready <= ready_pat[rx_phase % 8];
      rx_phase <= rx_phase + 1;
      if (rx_phase % 64 == 63) begin
        case ($urandom_range(0, 3))
          0: ready_pat <= 8'hff;
          1: ready_pat <= 8'($urandom()) | 8'h81;
          default: ready_pat <= 8'($urandom()) | 8'h01;
        endcase
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool[6];
    int n_random;
    int mode;
    int phase_len;
    int n_phase;

    // directed: empty pops, unused codes, fill to full, full pushes,
    // find and remove with and without a match, pops at both ends
    add_op(sdq_pkg::OP_POP_FRONT, 32'hdead_beef);
    add_op(sdq_pkg::OP_POP_BACK, 32'h0);
    add_op(OP_UNUSED_6, 32'hffff_ffff);
    add_op(OP_UNUSED_7, 32'h0);
    add_op(sdq_pkg::OP_PUSH_FRONT, 32'h0);
    add_op(sdq_pkg::OP_PUSH_BACK, 32'hffff_ffff);
    add_op(sdq_pkg::OP_PUSH_FRONT, 32'h8000_0001);
    for (int i = 0; i < QDEPTH - 3; i++)
      add_op(sdq_pkg::OP_PUSH_BACK, 32'h5a5a_0000 + i % 5);
    add_op(sdq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
    add_op(sdq_pkg::OP_PUSH_BACK, 32'h1234_5678);
    add_op(sdq_pkg::OP_FIND, 32'h5a5a_0002);
    add_op(sdq_pkg::OP_FIND, 32'h1234_5678);
    add_op(sdq_pkg::OP_REMOVE, 32'h5a5a_0003);
    add_op(sdq_pkg::OP_REMOVE, 32'h1234_5678);
    add_op(sdq_pkg::OP_POP_FRONT, 32'h0);
    add_op(sdq_pkg::OP_POP_BACK, 32'h0);
    add_drain();

    // random phases, each biased to fill, drain or mix, keys mostly from a small
    // pool so that finds and removes hit, duplicates included
    n_random = 0;
    n_phase = 0;
    while (n_random < 1520) begin
      mode = $urandom_range(MODE_FILL, MODE_MIXED);
      phase_len = $urandom_range(20, 60);
      foreach (key_pool[k]) key_pool[k] = $urandom();
      case ($urandom_range(0, 3))
        0: key_pool[0] = '0;
        1: key_pool[0] = '1;
        default: ;
      endcase
      for (int i = 0; i < phase_len; i++)
        add_op(pick_op(mode), ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 5)]
                                                         : KEY_W'($urandom()));
      n_random += phase_len;
      if (n_phase == 0 || $urandom_range(0, 3) == 0) add_drain();
      n_phase++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
